// ===== rtl/core/ddo_pkg.sv =====
// shared types, constants and tables for the differential drive odometry block
package ddo_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int CFG_W = 24;
	localparam int POS_W = 32;
	localparam int CNT_W = 32;
	localparam int HDG_W = 16;
	localparam int QUAL_W = 7;

	localparam logic [CFG_W-1:0] DPD_RESET = 24'd58107;
	localparam logic [CFG_W-1:0] HG_RESET = 24'd8427;

	localparam int CORDIC_STEPS = 28;
	localparam int CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 34'sd652032874;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

	typedef enum logic [0:0] {
		REG_DIST_PER_DEG,
		REG_HEADING_GAIN
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_P1,
		ST_P2,
		ST_WRITE
	} ddo_state_t;

endpackage

// ===== rtl/core/ddo_chan_if.sv =====
// sample and pose channel interfaces of the odometry block
interface ddo_sample_if;
	logic               valid;
	logic               ready;
	logic [6:0]         gps_quality;
	logic signed [31:0] gps_x;
	logic signed [31:0] gps_y;
	logic [15:0]        gps_heading;
	logic signed [31:0] left_count;
	logic signed [31:0] right_count;

	modport source(output valid, gps_quality, gps_x, gps_y, gps_heading, left_count,
		right_count, input ready);
	modport sink(input valid, gps_quality, gps_x, gps_y, gps_heading, left_count,
		right_count, output ready);
endinterface

interface ddo_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0]        pose_heading;
	logic               from_gps;

	modport source(output valid, pos_x, pos_y, pose_heading, from_gps, input ready);
	modport sink(input valid, pos_x, pos_y, pose_heading, from_gps, output ready);
endinterface

// ===== rtl/core/ddo_serial_mul.sv =====
// bit-serial signed by unsigned or signed multiplier, one multiplier bit per cycle
module ddo_serial_mul #(
	parameter int MW = 33,
	parameter int NW = 24,
	parameter bit NEG_MSB = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [MW-1:0] mcand,
	input  logic [NW-1:0]        mplier,
	output logic                 busy,
	output logic [MW+NW-1:0]     prod
);
	localparam int CW = $clog2(NW + 1);

	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic signed [MW-1:0] m_q;
	logic signed [MW:0]   hi_q;
	logic [NW-1:0]        lo_q;
	logic [NW-1:0]        mp_q;
	logic signed [MW+1:0] m_ext;
	logic signed [MW+1:0] addend;
	logic signed [MW+1:0] sum;
	logic                 last;

	assign last = (cnt_q == CW'(NW - 1));
	assign m_ext = {{2{m_q[MW-1]}}, m_q};

	always_comb begin
		addend = '0;
		if (mp_q[0]) begin
			addend = (NEG_MSB && last) ? -m_ext : m_ext;
		end
		sum = {hi_q[MW], hi_q} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q  <= mcand;
			hi_q <= '0;
			lo_q <= '0;
			mp_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[MW+1:1];
			lo_q <= {sum[0], lo_q[NW-1:1]};
			mp_q <= mp_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = {hi_q[MW-1:0], lo_q};

endmodule

// ===== rtl/core/ddo_cordic.sv =====
// iterative cordic, one rotation step per cycle, cos and sin in q30
module ddo_cordic #(
	parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic                  busy,
	output logic signed [31:0]    cos_v,
	output logic signed [31:0]    sin_v
);
	import ddo_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	logic                       busy_q;
	logic [IW-1:0]              i_q;
	logic                       flip_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [CORDIC_W-1:0] z_q;
	logic [31:0]                a32;
	logic                       flip;
	logic [31:0]                a_fold;
	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;
	logic signed [CORDIC_W-1:0] at;
	logic                       last;

	assign a32 = {angle, {(32 - ANGLE_BITS){1'b0}}};
	assign flip = a32[31] ^ a32[30];
	assign a_fold = {a32[31] ^ flip, a32[30:0]};
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = {{(CORDIC_W - 32){1'b0}}, ATAN_TAB[i_q]};
	assign last = (i_q == IW'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + IW'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_K_Q30;
			y_q    <= '0;
			z_q    <= {{(CORDIC_W - 32){a_fold[31]}}, a_fold};
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy = busy_q;
	assign cos_v = flip_q ? -x_q[31:0] : x_q[31:0];
	assign sin_v = flip_q ? -y_q[31:0] : y_q[31:0];

endmodule

// ===== rtl/core/diff_drive_odometry.sv =====
// odometry top level: gps override or dead reckoning from wheel encoders
//
//  channel  dir  payload
//  sample   in   gps_quality, gps_x, gps_y, gps_heading, left_count, right_count
//  pose     out  pos_x, pos_y, pose_heading, from_gps
//  wr_*     in   config write: wr_en, wr_idx, wr_data
//
// a dead-reckoned beat runs in two phases: 28 cordic steps set the first phase,
// the 32 bit-serial steps of the cosine and sine products set the second
// a gps beat goes from the start state straight to the write state
// reset clears the pose estimate and encoder history to zero and loads default gains
// the pose register holds a finished beat until taken; the next is accepted meanwhile
module diff_drive_odometry #(
	parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ddo_sample_if.sink                  sample,
	ddo_pose_if.source                  pose,
	input  logic                        wr_en,
	input  ddo_pkg::reg_idx_t           wr_idx,
	input  logic [ddo_pkg::CFG_W-1:0]   wr_data
);
	import ddo_pkg::*;

	ddo_state_t state_q, state_d;

	logic [CFG_W-1:0]      dpd_q;
	logic [CFG_W-1:0]      hg_q;
	logic signed [31:0]    last_left_q;
	logic signed [31:0]    last_right_q;
	logic [POS_W-1:0]      est_x_q;
	logic [POS_W-1:0]      est_y_q;
	logic [ANGLE_BITS-1:0] est_h_q;
	logic                  out_valid_q;

	logic               gps_q;
	logic [POS_W-1:0]   gx_q;
	logic [POS_W-1:0]   gy_q;
	logic [HDG_W-1:0]   gh_q;
	logic signed [31:0] lc_q;
	logic signed [31:0] rc_q;

	logic [POS_W-1:0] pos_x_q;
	logic [POS_W-1:0] pos_y_q;
	logic [HDG_W-1:0] pose_h_q;
	logic             from_gps_q;

	logic p1_start, p2_start, commit;

	logic signed [32:0] diff_l, diff_r;
	logic               busy_l, busy_r, busy_c, busy_x, busy_y, busy_h;
	logic [56:0]        prod_l, prod_r;
	logic signed [48:0] dl, dr;
	logic [49:0]        sum_lr;
	logic signed [48:0] avg;
	logic signed [49:0] dd;
	logic signed [31:0] cos_v, sin_v;
	logic [80:0]        prod_x, prod_y;
	logic [73:0]        prod_h;

	logic [31:0]           g32;
	logic [POS_W-1:0]      est_x_n, est_y_n;
	logic [ANGLE_BITS-1:0] est_h_n;
	logic [31:0]           h32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpd_q <= DPD_RESET;
			hg_q  <= HG_RESET;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_DIST_PER_DEG: dpd_q <= wr_data;
				REG_HEADING_GAIN: hg_q  <= wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		p1_start     = 1'b0;
		p2_start     = 1'b0;
		commit       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (gps_q) begin
					state_d = ST_WRITE;
				end else begin
					p1_start = 1'b1;
					state_d  = ST_P1;
				end
			end
			ST_P1: begin
				if (!busy_l && !busy_r && !busy_c) begin
					p2_start = 1'b1;
					state_d  = ST_P2;
				end
			end
			ST_P2: begin
				if (!busy_x && !busy_y && !busy_h) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || pose.ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			gps_q <= (sample.gps_quality != '0);
			gx_q  <= sample.gps_x;
			gy_q  <= sample.gps_y;
			gh_q  <= sample.gps_heading;
			lc_q  <= sample.left_count;
			rc_q  <= sample.right_count;
		end
	end

	// encoder distances and heading rotation
	assign diff_l = {last_left_q[31], last_left_q} - {lc_q[31], lc_q};
	assign diff_r = {last_right_q[31], last_right_q} - {rc_q[31], rc_q};

	ddo_serial_mul #(.MW(33), .NW(CFG_W), .NEG_MSB(1'b0)) u_mul_l (
		.clk(clk), .arst_n(arst_n), .start(p1_start), .mcand(diff_l), .mplier(dpd_q),
		.busy(busy_l), .prod(prod_l)
	);

	ddo_serial_mul #(.MW(33), .NW(CFG_W), .NEG_MSB(1'b0)) u_mul_r (
		.clk(clk), .arst_n(arst_n), .start(p1_start), .mcand(diff_r), .mplier(dpd_q),
		.busy(busy_r), .prod(prod_r)
	);

	ddo_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(p1_start), .angle(est_h_q), .busy(busy_c),
		.cos_v(cos_v), .sin_v(sin_v)
	);

	assign dl = prod_l[56:8];
	assign dr = prod_r[56:8];
	assign sum_lr = {dl[48], dl} + {dr[48], dr};
	assign avg = sum_lr[49:1];
	assign dd = {dr[48], dr} - {dl[48], dl};

	// position and heading steps
	ddo_serial_mul #(.MW(49), .NW(32), .NEG_MSB(1'b1)) u_mul_x (
		.clk(clk), .arst_n(arst_n), .start(p2_start), .mcand(avg), .mplier(cos_v),
		.busy(busy_x), .prod(prod_x)
	);

	ddo_serial_mul #(.MW(49), .NW(32), .NEG_MSB(1'b1)) u_mul_y (
		.clk(clk), .arst_n(arst_n), .start(p2_start), .mcand(avg), .mplier(sin_v),
		.busy(busy_y), .prod(prod_y)
	);

	ddo_serial_mul #(.MW(50), .NW(CFG_W), .NEG_MSB(1'b0)) u_mul_h (
		.clk(clk), .arst_n(arst_n), .start(p2_start), .mcand(dd), .mplier(hg_q),
		.busy(busy_h), .prod(prod_h)
	);

	assign g32 = {gh_q, 16'b0};

	always_comb begin
		if (gps_q) begin
			est_x_n = gx_q;
			est_y_n = gy_q;
			est_h_n = g32[31 -: ANGLE_BITS];
		end else begin
			est_x_n = est_x_q + prod_x[61:30];
			est_y_n = est_y_q + prod_y[61:30];
			est_h_n = est_h_q + prod_h[16 +: ANGLE_BITS];
		end
	end

	assign h32 = {est_h_n, {(32 - ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
			est_x_q      <= '0;
			est_y_q      <= '0;
			est_h_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (p1_start) begin
				last_left_q  <= lc_q;
				last_right_q <= rc_q;
			end
			if (commit) begin
				est_x_q     <= est_x_n;
				est_y_q     <= est_y_n;
				est_h_q     <= est_h_n;
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pos_x_q    <= est_x_n;
			pos_y_q    <= est_y_n;
			pose_h_q   <= h32[31:16];
			from_gps_q <= gps_q;
		end
	end

	assign pose.valid        = out_valid_q;
	assign pose.pos_x        = pos_x_q;
	assign pose.pos_y        = pos_y_q;
	assign pose.pose_heading = pose_h_q;
	assign pose.from_gps     = from_gps_q;

`ifndef SYNTHESIS
	a_valid_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose.valid) |-> $past(state_q) == ST_WRITE)
		else $error("pose beat raised outside write");

	a_gps_keeps_encoders: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START && gps_q) |=>
		(state_q == ST_WRITE && $stable(last_left_q) && $stable(last_right_q)))
		else $error("gps beat disturbed encoder history");

	a_cordic_idle_in_p2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P2) |-> !busy_c && !busy_l && !busy_r)
		else $error("first phase still running in second phase");

	a_from_gps_tag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose.valid) |-> pose.from_gps == $past(gps_q))
		else $error("pose source tag mismatch");
`endif

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of the differential drive odometry block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ddo_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_BEATS = 258;
	localparam int TAIL_CYCLES = 70;
	localparam longint CORDIC_START = 64'sd652032874;
	localparam longint TURN_ATAN [28] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
	};

	typedef struct packed {
		logic [6:0]         quality;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        hdg;
		logic signed [31:0] left;
		logic signed [31:0] right;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        hdg;
		logic               gps;
	} pose_t;

	typedef struct {
		sample_t beat;
		bit      typed;
		pose_t   want;
	} steer_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	reg_idx_t wr_idx;
	logic [CFG_W-1:0] wr_data;

	ddo_sample_if sample_ch();
	ddo_pose_if pose_ch();

	diff_drive_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.pose(pose_ch),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data)
	);

	always #2 clk = ~clk;

	// pose estimate held alongside the block
	logic [23:0] dist_gain = DPD_RESET;
	logic [23:0] turn_gain = HG_RESET;
	longint enc_left = 0;
	longint enc_right = 0;
	logic [31:0] est_x = '0;
	logic [31:0] est_y = '0;
	logic [15:0] est_hdg = '0;

	pose_t poses_due [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int faults = 0;
	int stall_cycles = 0;
	int samples_sent = 0;
	int fixes_sent = 0;
	int poses_seen = 0;

	steer_row_t steer_rows [22] = '{
		'{'{7'd0, 32'h0, 32'h0, 16'h0, 32'sd0, 32'sd0}, 1'b1, '{32'h0, 32'h0, 16'h0, 1'b0}},
		'{'{7'd100, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 32'sd5, 32'sd6}, 1'b1,
			'{32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1}},
		'{'{7'd127, 32'h80000000, 32'h7FFFFFFF, 16'h0, -32'sd1, -32'sd1}, 1'b1,
			'{32'h80000000, 32'h7FFFFFFF, 16'h0, 1'b1}},
		'{'{7'd1, 32'h0, 32'h0, 16'h4000, 32'sd0, 32'sd0}, 1'b1,
			'{32'h0, 32'h0, 16'h4000, 1'b1}},
		'{'{7'd0, 32'h55555555, 32'hAAAAAAAA, 16'hAAAA, 32'sd0, 32'sd0}, 1'b1,
			'{32'h0, 32'h0, 16'h4000, 1'b0}},
		'{'{7'd0, 32'hAAAAAAAA, 32'h55555555, 16'h5555, -32'sd1000, -32'sd1000}, 1'b0, '0},
		'{'{7'd0, 32'h0, 32'h0, 16'h0, -32'sd2000, -32'sd1990}, 1'b0, '0},
		'{'{7'd1, 32'h7FFF0000, 32'h7FFF0000, 16'h0, 32'sd0, 32'sd0}, 1'b1,
			'{32'h7FFF0000, 32'h7FFF0000, 16'h0, 1'b1}},
		'{'{7'd0, 32'h0, 32'h0, 16'h0, -32'sd402000, -32'sd401990}, 1'b0, '0},
		'{'{7'd0, 32'hFFFFFFFF, 32'h0, 16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000}, 1'b0, '0},
		'{'{7'd0, 32'h0, 32'hFFFFFFFF, 16'h0, 32'sh80000000, 32'sh7FFFFFFF}, 1'b0, '0},
		'{'{7'd1, 32'h0, 32'h0, 16'h8000, 32'sd0, 32'sd0}, 1'b1,
			'{32'h0, 32'h0, 16'h8000, 1'b1}},
		'{'{7'd0, 32'h0, 32'h0, 16'h0, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{7'd1, 32'h12345678, 32'h9ABCDEF0, 16'hC000, 32'sd0, 32'sd0}, 1'b1,
			'{32'h12345678, 32'h9ABCDEF0, 16'hC000, 1'b1}},
		'{'{7'd0, 32'h0, 32'h0, 16'h0, -32'sd500, -32'sd500}, 1'b0, '0},
		'{'{7'd1, 32'h0, 32'h0, 16'h3FFF, 32'sd0, 32'sd0}, 1'b1,
			'{32'h0, 32'h0, 16'h3FFF, 1'b1}},
		'{'{7'd0, 32'h0, 32'h0, 16'h0, -32'sd1000, -32'sd900}, 1'b0, '0},
		'{'{7'd1, 32'h0, 32'h0, 16'hBFFF, 32'sd0, 32'sd0}, 1'b1,
			'{32'h0, 32'h0, 16'hBFFF, 1'b1}},
		'{'{7'd0, 32'h0, 32'h0, 16'h0, -32'sd1500, -32'sd1500}, 1'b0, '0},
		'{'{7'd1, 32'h0, 32'h0, 16'h4000, 32'sd0, 32'sd0}, 1'b1,
			'{32'h0, 32'h0, 16'h4000, 1'b1}},
		'{'{7'd0, 32'h0, 32'h0, 16'h0, -32'sd2000, -32'sd2100}, 1'b0, '0},
		'{'{7'd0, 32'h55555555, 32'hAAAAAAAA, 16'hFFFF, -32'sd2000, -32'sd2100}, 1'b0, '0}
	};

	function automatic pose_t advance_pose(input sample_t smp);
		longint dl, dr, avg, cx, cy, cz, xs, ys;
		logic [31:0] ang;
		logic [63:0] px, py, ph;
		logic flip;
		pose_t p;
		if (smp.quality != 7'd0) begin
			est_x = smp.x;
			est_y = smp.y;
			est_hdg = smp.hdg;
			p.gps = 1'b1;
		end else begin
			dl = ((enc_left - longint'($signed(smp.left))) * longint'(dist_gain)) >>> 8;
			dr = ((enc_right - longint'($signed(smp.right))) * longint'(dist_gain)) >>> 8;
			avg = (dl + dr) >>> 1;
			enc_left = longint'($signed(smp.left));
			enc_right = longint'($signed(smp.right));
			// fold the back half-turn onto the front, negate after
			ang = {est_hdg, 16'h0};
			flip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
			if (flip) begin
				ang = ang + 32'h8000_0000;
			end
			cx = CORDIC_START;
			cy = 0;
			cz = longint'($signed(ang));
			for (int i = 0; i < 28; i++) begin
				xs = cx >>> i;
				ys = cy >>> i;
				if (cz >= 0) begin
					cx = cx - ys;
					cy = cy + xs;
					cz = cz - TURN_ATAN[i];
				end else begin
					cx = cx + ys;
					cy = cy - xs;
					cz = cz + TURN_ATAN[i];
				end
			end
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end
			px = avg * cx;
			py = avg * cy;
			ph = (dr - dl) * longint'(turn_gain);
			est_x = est_x + px[61:30];
			est_y = est_y + py[61:30];
			est_hdg = est_hdg + ph[31:16];
			p.gps = 1'b0;
		end
		p.x = est_x;
		p.y = est_y;
		p.hdg = est_hdg;
		return p;
	endfunction

	task automatic push_sample(input sample_t smp, input bit typed, input pose_t typed_pose);
		pose_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.gps_quality <= smp.quality;
		sample_ch.gps_x <= smp.x;
		sample_ch.gps_y <= smp.y;
		sample_ch.gps_heading <= smp.hdg;
		sample_ch.left_count <= smp.left;
		sample_ch.right_count <= smp.right;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		predicted = advance_pose(smp);
		poses_due.push_back(typed ? typed_pose : predicted);
		samples_sent++;
		if (smp.quality != 7'd0) begin
			fixes_sent++;
		end
	endtask

	task automatic drain_poses();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (poses_due.size() != 0) @(negedge clk);
	endtask

	task automatic set_gains(input logic [23:0] d, input logic [23:0] h);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= REG_DIST_PER_DEG;
		wr_data <= d;
		@(negedge clk);
		wr_idx <= REG_HEADING_GAIN;
		wr_data <= h;
		@(negedge clk);
		wr_en <= 1'b0;
		dist_gain = d;
		turn_gain = h;
	endtask

	// pose checker and stall counter
	always @(posedge clk) begin
		pose_t got;
		pose_t want;
		if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
			(pose_ch.valid === 1'b1 && pose_ch.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (arst_n === 1'b1 && pose_ch.valid === 1'b1 && pose_ch.ready === 1'b1) begin
			got = '{pose_ch.pos_x, pose_ch.pos_y, pose_ch.pose_heading, pose_ch.from_gps};
			poses_seen++;
			if (poses_due.size() == 0) begin
				$display("%0t: pose beat with none expected: x=%h y=%h hdg=%h gps=%b",
					$time, got.x, got.y, got.hdg, got.gps);
				faults++;
			end else begin
				want = poses_due.pop_front();
				if (got !== want) begin
					$display("%0t: pose expected x=%h y=%h hdg=%h gps=%b, got x=%h y=%h hdg=%h gps=%b",
						$time, want.x, want.y, want.hdg, want.gps,
						got.x, got.y, got.hdg, got.gps);
					faults++;
				end
			end
		end
	end

	initial begin
		pose_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			pose_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		sample_t smp;
		int pick;
		int step;
		logic [23:0] d;
		logic [23:0] h;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_idx <= REG_DIST_PER_DEG;
		wr_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.gps_quality <= '0;
		sample_ch.gps_x <= '0;
		sample_ch.gps_y <= '0;
		sample_ch.gps_heading <= '0;
		sample_ch.left_count <= '0;
		sample_ch.right_count <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 31;
		recv_idle_pct = 77;
		foreach (steer_rows[i]) begin
			push_sample(steer_rows[i].beat, steer_rows[i].typed, steer_rows[i].want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain_poses();
			case (ph)
				0: begin d = 24'hFFFFFF; h = 24'hFFFFFF; end
				1: begin d = 24'd0; h = 24'd0; end
				2: begin d = 24'($urandom()); h = 24'($urandom()); end
				3: begin d = 24'd1; h = 24'd1; end
				4: begin d = DPD_RESET; h = HG_RESET; end
				default: begin d = 24'($urandom_range(200000)); h = 24'($urandom()); end
			endcase
			set_gains(d, h);
			if (ph == 2) begin
				send_idle_pct = 77;
				recv_idle_pct = 31;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (PHASE_BEATS) begin
				pick = int'($urandom_range(99));
				smp.quality = 7'd0;
				smp.x = $urandom();
				smp.y = $urandom();
				smp.hdg = 16'($urandom());
				smp.left = $urandom();
				smp.right = $urandom();
				if (pick < 15) begin
					smp.quality = 7'($urandom_range(127, 1));
				end else if (pick >= 25) begin
					// plausible wheel motion: mostly forward, small turn
					step = int'($urandom_range(600)) - 150;
					smp.left = 32'(enc_left - longint'(step));
					smp.right = 32'(enc_right - longint'(step + int'($urandom_range(40)) - 20));
				end
				push_sample(smp, 1'b0, '0);
			end
		end

		drain_poses();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("run covered %0d samples (%0d with a gps fix) and %0d checked poses",
			samples_sent, fixes_sent, poses_seen);
		$display("over reset gains and six further gain settings, %0d mismatches", faults);
		if (faults == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== diff_drive_odometry.f =====
rtl/core/ddo_pkg.sv
rtl/core/ddo_chan_if.sv
rtl/core/ddo_serial_mul.sv
rtl/core/ddo_cordic.sv
rtl/core/diff_drive_odometry.sv
test/testbench.sv
